/* hw/rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants
// Item, task and result types for the screen projection unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned NumCoefs  = 12;
  localparam int unsigned CoefIdxW  = 4;
  localparam int unsigned DimW      = 14;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned AccW      = 57;
  localparam int unsigned TSatLog   = 40;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 1'b1;

  typedef enum logic {
    FuncLoad = 1'b0,
    FuncProj = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic [CoefIdxW-1:0] coef_index;
    logic signed [31:0]  coef_value;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_item_t;

  // Point task handed from the front end to the back end.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } task_t;

  typedef enum logic [2:0] {
    StIdle,
    StMac,
    StCheck,
    StDivX,
    StDivY,
    StOut
  } be_state_e;

endpackage

/* hw/rtl/pps_if.sv */
// ----------------------------------------------------------------------------
// pps_in_if / pps_out_if: valid-ready channels
// Handshake channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface pps_in_if import pps_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_out_if import pps_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pps_front.sv */
// ----------------------------------------------------------------------------
// pps_front: item intake
// Accepts items, performs coefficient loads, queues point tasks (2 deep).
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pps_in_if.sink               in_ch,
  output logic                 load_we_o,
  output logic [CoefIdxW-1:0]  load_idx_o,
  output logic signed [31:0]   load_val_o,
  output logic                 task_valid_o,
  output task_t                task_o,
  input  logic                 task_ready_i,
  input  logic                 coef_busy_i
);

  task_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop, is_proj;

  // Hold a load until no earlier point still needs the old coefficients.
  assign is_proj      = (in_ch.data.func == FuncProj);
  assign in_ch.ready  = is_proj ? (cnt_q != 2'd2) : (cnt_q == 2'd0 && !coef_busy_i);
  assign push         = in_ch.valid && in_ch.ready && is_proj;
  assign pop          = task_valid_o && task_ready_i;
  assign task_valid_o = (cnt_q != 2'd0);
  assign task_o       = fifo_q[rd_ptr_q];

  assign load_we_o  = in_ch.valid && in_ch.ready && !is_proj;
  assign load_idx_o = in_ch.data.coef_index;
  assign load_val_o = in_ch.data.coef_value;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{in_ch.data.point_x, in_ch.data.point_y, in_ch.data.point_z};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("task queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !task_valid_o) else $error("empty queue offers task");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("queue lost a task");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_we_o |-> cnt_q == 2'd0 && !coef_busy_i) else $error("load passed a point");

endmodule

/* hw/rtl/pps_div.sv */
// ----------------------------------------------------------------------------
// pps_div: serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_div import pps_pkg::*; #(
  parameter int unsigned NW = 72,
  parameter int unsigned DW = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW:0]     rem_q;
  logic [DW-1:0]   den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DW:0]     rem_sh, rem_sub;

  assign rem_sh  = {rem_q[DW-1:0], quo_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!rem_sub[DW]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/pps_back.sv */
// ----------------------------------------------------------------------------
// pps_back: projection engine
// Sequential dot products on one multiplier, divide, map and saturate.
// ----------------------------------------------------------------------------
module pps_back import pps_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_we_i,
  input  logic [CoefIdxW-1:0] load_idx_i,
  input  logic signed [31:0]  load_val_i,
  input  logic [DimW-1:0]     width_i,
  input  logic [DimW-1:0]     height_i,
  input  logic                task_valid_i,
  input  task_t               task_i,
  output logic                task_ready_o,
  output logic                coef_busy_o,
  pps_out_if.source           out_ch
);

  localparam logic signed [AccW-1:0] MinW =
    AccW'(((64'd1 << FracBits) + 64'd50) / 64'd100);
  localparam int unsigned NW = AccW + DimW + FracBits;
  localparam int unsigned DW = AccW + 1;
  localparam logic [63:0] TSat = 64'd1 << TSatLog;
  localparam logic signed [63:0] HalfOne = 64'sd1 <<< (FracBits - 1);

  logic signed [31:0] coef_q [NumCoefs];
  task_t              pt_q;
  be_state_e          st_q, st_d;
  logic [3:0]         step_q;
  logic signed [63:0] prod_q;
  logic               prod_v_q;
  logic [3:0]         pidx_q;
  logic signed [AccW-1:0] acc_q [3];
  logic signed [63:0] tx_q;
  out_item_t          res_q;
  logic               res_v_q;

  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] opa, opb;
  logic signed [AccW-1:0] fl;
  logic               div_start, div_done;
  logic [NW-1:0]      div_num, div_q;
  logic [DW-1:0]      div_den;
  logic signed [AccW-1:0] cur;
  logic [AccW-1:0]    mag;
  logic [DimW-1:0]    kdim;
  logic               res_neg;
  logic [63:0]        tmag;
  logic signed [63:0] tsgn, sx, sy;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

  // Coefficients are read only while the dot products run.
  assign coef_busy_o = (st_q == StMac);

  // Multiplier operand select: step = row*4 + col, col 3 is the offset.
  assign row = step_q[3:2];
  assign col = step_q[1:0];
  always_comb begin
    opa = coef_q[{row, 2'(col)}];
    case (col)
      2'd0:    opb = pt_q.point_x;
      2'd1:    opb = pt_q.point_y;
      default: opb = pt_q.point_z;
    endcase
  end
  // Floor of product (arithmetic shift floors).
  assign fl = AccW'(prod_q >>> FracBits);

  // The x divide starts from StCheck, the y divide from StDivX.
  assign cur  = (st_q == StCheck) ? acc_q[0] : acc_q[1];
  assign mag  = cur[AccW-1] ? AccW'(-cur) : AccW'(cur);
  assign kdim = (st_q == StCheck) ? width_i : height_i;
  assign div_num = NW'(mag) * NW'(kdim) << FracBits;
  assign div_den = DW'({acc_q[2], 1'b0});

  // Sign of the quotient that is finishing: x in StDivX, y afterwards.
  assign res_neg = (st_q == StDivX) ? acc_q[0][AccW-1] : acc_q[1][AccW-1];

  pps_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_q)
  );

  always_comb begin
    tmag = (div_q > NW'(TSat)) ? TSat : 64'(div_q);
    tsgn = res_neg ? -$signed(tmag) : $signed(tmag);
    sx = $signed(64'(width_i)) * HalfOne + tx_q + HalfOne;
    sy = $signed(64'(height_i)) * HalfOne - tsgn - HalfOne;
  end

  always_comb begin
    st_d         = st_q;
    task_ready_o = 1'b0;
    div_start    = 1'b0;
    case (st_q)
      StIdle: if (task_valid_i) begin
        task_ready_o = 1'b1;
        st_d = StMac;
      end
      StMac: if (prod_v_q && pidx_q == 4'd11 && step_q == 4'd12) st_d = StCheck;
      StCheck: begin
        if (acc_q[2] < MinW) st_d = StOut;
        else begin
          st_d = StDivX;
          div_start = 1'b1;
        end
      end
      StDivX: if (div_done) begin
        st_d = StDivY;
        div_start = 1'b1;
      end
      StDivY: if (div_done) st_d = StOut;
      StOut: if (!res_v_q || out_ch.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (task_ready_o) pt_q <= task_i;
    prod_q <= opa * opb;
    pidx_q <= step_q;
    if (st_q == StIdle) begin
      acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0;
    end else if (st_q == StMac && prod_v_q) begin
      if (pidx_q[1:0] == 2'd3)
        acc_q[pidx_q[3:2]] <= acc_q[pidx_q[3:2]] + AccW'(coef_q[pidx_q]);
      else
        acc_q[pidx_q[3:2]] <= acc_q[pidx_q[3:2]] + fl;
    end
    if (st_q == StDivX && div_done) tx_q <= tsgn;
    if (st_q == StOut && (!res_v_q || out_ch.ready)) begin
      if (acc_q[2] < MinW) res_q <= '0;
      else res_q <= '{1'b1, sat32(sx), sat32(sy)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      step_q   <= '0;
      prod_v_q <= 1'b0;
      res_v_q  <= 1'b0;
      for (int i = 0; i < NumCoefs; i++) coef_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (load_we_i && load_idx_i < CoefIdxW'(NumCoefs)) coef_q[load_idx_i] <= load_val_i;
      if (st_q == StMac && step_q != 4'd12) begin
        step_q   <= step_q + 4'd1;
        prod_v_q <= 1'b1;
      end else begin
        step_q   <= (st_q == StMac) ? 4'd12 : 4'd0;
        prod_v_q <= 1'b0;
      end
      if (out_ch.valid && out_ch.ready) res_v_q <= 1'b0;
      if (st_q == StOut && (!res_v_q || out_ch.ready)) res_v_q <= 1'b1;
    end
  end

  assign out_ch.valid = res_v_q;
  assign out_ch.data  = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !out_ch.ready |=> res_v_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    task_ready_o |-> st_q == StIdle) else $error("task taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> st_q != StIdle) else $error("divide without task");

endmodule

/* hw/rtl/perspective_project_to_screen_unit.sv */
// ----------------------------------------------------------------------------
// perspective_project_to_screen_unit: world point to screen pixel projection
// Coefficient loads and point projections over valid-ready channels.
// ----------------------------------------------------------------------------
// Sequence: a point passes the task queue, the dot products on the shared
//   multiplier, the visibility check, two serial divides of the 87-bit
//   dividend and the output register; a hidden point skips the divides.
// Flow: one point projects at a time while up to two more queue; a load waits
//   until no queued or multiplying point still reads the coefficients.
// Reset: coefficients clear to zero, width 1280, height 720, channels empty.
module perspective_project_to_screen_unit import pps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pps_in_if.sink              in_ch,
  pps_out_if.source           out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DimW-1:0]     cfg_data_i
);

  logic [DimW-1:0]     width_q, height_q;
  logic                load_we;
  logic [CoefIdxW-1:0] load_idx;
  logic signed [31:0]  load_val;
  logic                task_valid, task_ready;
  logic                coef_busy;
  task_t               tsk;

  // Viewport size registers; write only while idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1280);
      height_q <= DimW'(720);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: take items, apply loads once earlier points are past the
  // multiplies, queue points.
  pps_front u_front (
    .clk_i, .rst_ni, .in_ch,
    .load_we_o(load_we), .load_idx_o(load_idx), .load_val_o(load_val),
    .task_valid_o(task_valid), .task_o(tsk), .task_ready_i(task_ready),
    .coef_busy_i(coef_busy)
  );

  // Back: multiply, divide, map, hold result until taken.
  pps_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .load_we_i(load_we), .load_idx_i(load_idx), .load_val_i(load_val),
    .width_i(width_q), .height_i(height_q),
    .task_valid_i(task_valid), .task_i(tsk), .task_ready_o(task_ready),
    .coef_busy_o(coef_busy),
    .out_ch
  );

endmodule

/* tb/pps_scoreboard.sv */
// ----------------------------------------------------------------------------
// pps_scoreboard: projection predictor and result checker
// Watches the item, result and register channels of the projection unit,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module pps_scoreboard import pps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  pps_in_if               in_mon,
  pps_out_if              out_mon,
  input  logic            cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              results_o,
  output int              visible_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FracBits = 16;
  localparam longint      MinW     = ((64'sd1 <<< FracBits) + 50) / 100;
  localparam longint      HalfOne  = 64'sd1 <<< (FracBits - 1);
  localparam logic [127:0] TSat    = 128'd1 << TSatLog;

  logic signed [31:0] coef_q [NumCoefs];
  logic [DimW-1:0]    width_q;
  logic [DimW-1:0]    height_q;
  out_item_t          screen_q [$];

  function automatic longint clip_row(int row, longint px, longint py, longint pz);
    longint acc;
    acc = (longint'(coef_q[row*4+0]) * px) >>> FracBits;
    acc += (longint'(coef_q[row*4+1]) * py) >>> FracBits;
    acc += (longint'(coef_q[row*4+2]) * pz) >>> FracBits;
    acc += longint'(coef_q[row*4+3]);
    return acc;
  endfunction

  // num*k*2^FracBits/d truncated toward zero, magnitude clamped
  function automatic longint scaled_offset(longint num, logic [DimW-1:0] dim, longint d);
    logic [127:0] mag;
    logic [127:0] q;
    longint       res;
    if (dim == 0) return 0;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q   = (mag * (128'(dim) << FracBits)) / 128'(d);
    if (q > TSat) q = TSat;
    res = longint'(q[63:0]);
    return (num < 0) ? -res : res;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_item_t project_point(in_item_t it);
    out_item_t r;
    longint    px, py, pz, cx, cy, cw;
    px = longint'(it.point_x);
    py = longint'(it.point_y);
    pz = longint'(it.point_z);
    cx = clip_row(0, px, py, pz);
    cy = clip_row(1, px, py, pz);
    cw = clip_row(2, px, py, pz);
    r  = '0;
    if (cw >= MinW) begin
      r.visible  = 1'b1;
      r.screen_x = sat32(longint'(width_q) * HalfOne
                         + scaled_offset(cx, width_q, 2 * cw) + HalfOne);
      r.screen_y = sat32(longint'(height_q) * HalfOne
                         - scaled_offset(cy, height_q, 2 * cw) - HalfOne);
    end
    return r;
  endfunction

  task automatic report(string what, longint exp_v, longint act_v);
    if (fail_count_o < 10)
      $display("[%0t] mismatch %s: expected %0d actual %0d", $realtime, what, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      foreach (coef_q[i]) coef_q[i] <= '0;
      width_q      <= 14'd1280;
      height_q     <= 14'd720;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      visible_o    <= 0;
      screen_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgWidth) width_q <= cfg_data_i;
        else if (cfg_idx_i == CfgHeight) height_q <= cfg_data_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.data.func == FuncLoad) begin
          if (in_mon.data.coef_index < NumCoefs)
            coef_q[in_mon.data.coef_index] <= in_mon.data.coef_value;
        end else begin
          screen_q.push_back(project_point(in_mon.data));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        results_o <= results_o + 1;
        if (out_mon.data.visible) visible_o <= visible_o + 1;
        if (screen_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("[%0t] result with nothing expected", $realtime);
          fail_count_o++;
        end else begin
          exp_r = screen_q.pop_front();
          if (out_mon.data.visible !== exp_r.visible)
            report("visible", exp_r.visible, out_mon.data.visible);
          if (out_mon.data.screen_x !== exp_r.screen_x)
            report("screen_x", exp_r.screen_x, out_mon.data.screen_x);
          if (out_mon.data.screen_y !== exp_r.screen_y)
            report("screen_y", exp_r.screen_y, out_mon.data.screen_y);
        end
      end
      pending_o <= screen_q.size();
    end
  end
endmodule

/* tb/tb_perspective_project_to_screen_unit.sv */
// ----------------------------------------------------------------------------
// tb_perspective_project_to_screen_unit: testbench top
// Drives coefficient loads, point projections and viewport size writes into
// the projection unit under random handshake idling; the scoreboard checks.
// ----------------------------------------------------------------------------
module tb_perspective_project_to_screen_unit;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q         = 65536;
  localparam int Settle    = 320;    // idle wait at the end of a drain
  localparam int HoldOff   = 2000;
  localparam int WatchLim  = 20000;
  localparam int SegItems  = 210;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DimW-1:0] cfg_data;
  int   fail_count, pending, results, visible_cnt;
  int   send_idle, recv_idle;
  bit   hold_req;
  int   idle_cycles;
  int   n_loads, n_points;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();

  perspective_project_to_screen_unit dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  pps_scoreboard u_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .visible_o   (visible_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLim) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // unit fills its task queue and stalls its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Mix of extremes, full random and moderate values near unit scale.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2, 3:    return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic in_item_t make_load(int idx, logic [31:0] val);
    in_item_t it;
    it.func       = FuncLoad;
    it.coef_index = idx[CoefIdxW-1:0];
    it.coef_value = val;
    // point fields are don't-care on a load; toggle them anyway
    it.point_x    = $urandom;
    it.point_y    = $urandom;
    it.point_z    = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it.func       = FuncProj;
    it.coef_index = $urandom;
    it.coef_value = $urandom;
    it.point_x    = x;
    it.point_y    = y;
    it.point_z    = z;
    return it;
  endfunction

  // Offer one transaction, with random gaps before it; return at the edge
  // where it was accepted, leaving valid high for a back-to-back follower.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    if (it.func == FuncLoad) n_loads++;
    else n_points++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every expected result, then let a load settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_size(logic [DimW-1:0] w, logic [DimW-1:0] h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgWidth;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= CfgHeight;
    cfg_data <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Well-formed frame: load the whole matrix with moderate values, w row
  // biased toward a positive offset so most points land in front.
  task automatic load_matrix();
    for (int i = 0; i < NumCoefs; i++) begin
      if (i == 11) send(make_load(i, $urandom_range(Q / 2, 8 * Q)));
      else send(make_load(i, 32'($signed($urandom_range(0, 4 * Q)) - 2 * Q)));
    end
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 25)
      send(make_load($urandom_range(15), pick_value()));
    else
      send(make_point(pick_value(), pick_value(), pick_value()));
  endtask

  logic [DimW-1:0] seg_w [5];
  logic [DimW-1:0] seg_h [5];

  initial begin
    rst_n       = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CfgWidth;
    cfg_data    <= '0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    n_loads     = 0;
    n_points    = 0;
    send_idle   = 12;
    recv_idle   = 63;
    seg_w = '{14'd1, 14'd8192, 14'd0, 14'd16383, 14'd640};
    seg_h = '{14'd1, 14'd8192, 14'd16383, 14'd0, 14'd480};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero matrix first, so the point is behind the viewer.
    send(make_point(0, 0, Q));
    // Identity-like rows: clip x = px, y = py, w = pz.
    send(make_load(0, Q));
    send(make_load(5, Q));
    send(make_load(10, Q));
    send(make_point(0, 0, Q));
    send(make_point(Q, -Q, Q));
    // Hold w right at the visibility threshold and just below it.
    send(make_point(Q, Q, 655));
    send(make_point(Q, Q, 654));
    send(make_point(0, 0, 0));
    send(make_point(0, 0, -Q));
    // Saturate both offsets.
    send(make_point(32'h7fffffff, 32'h80000000, Q));
    send(make_point(32'h80000000, 32'h7fffffff, 655));
    // Out-of-range slots must leave the matrix untouched.
    send(make_load(12, 32'h7fffffff));
    send(make_load(15, 32'h80000000));
    send(make_point(Q, Q, 2 * Q));
    // Extreme offsets and the largest product magnitude.
    send(make_load(3, 32'h7fffffff));
    send(make_load(7, 32'h80000000));
    send(make_point(0, 0, Q));
    send(make_load(0, 32'h80000000));
    send(make_point(32'h80000000, 0, Q));
    send(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    drain();

    // Random segments, each with its own viewport setting.
    for (int s = 0; s < 5; s++) begin
      write_size(seg_w[s], seg_h[s]);
      if (s == 2) begin
        send_idle = 63;
        recv_idle = 12;
      end else if (s == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      load_matrix();
      for (int n = 0; n < SegItems; n++) begin
        if (s == 4 && n == 40) hold_req = 1'b1;
        if (n % 64 == 63) load_matrix();
        random_item();
      end
      drain();
    end
    write_size(14'd1280, 14'd720);
    send(make_point(Q, Q, Q));
    drain();

    $display("Sent %0d loads and %0d points over six viewport settings", n_loads, n_points);
    $display("Checked %0d results, %0d of them visible", results, visible_cnt);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
